/* rtl/tlcs_pkg.sv */
// Shared types, constants and address helpers for the top-k logit cache scatter block.
// Depends on nothing; every other file in rtl but tlcs_ram imports it.
package tlcs_pkg;

    // Store geometry.
    localparam int SLOTS     = 64;
    localparam int MAX_STEPS = 8;
    localparam int MAX_TOP_K = 8;
    localparam int VOCAB     = 4096;

    localparam int     ROWS        = SLOTS * MAX_STEPS;
    localparam longint LOGIT_DEPTH = longint'(ROWS) * longint'(VOCAB);
    localparam longint CID_DEPTH   = longint'(ROWS) * longint'(MAX_TOP_K);
    localparam longint CLR_DEPTH   = (LOGIT_DEPTH > CID_DEPTH) ? LOGIT_DEPTH : CID_DEPTH;

    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LADDR_W = $clog2(LOGIT_DEPTH);
    localparam int CADDR_W = (CID_DEPTH > 1) ? $clog2(CID_DEPTH) : 1;
    localparam int CLR_W   = $clog2(CLR_DEPTH);
    localparam int KIDX_W  = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;

    // Field widths of the stream items.
    localparam int SLOT_W   = 7;
    localparam int STEP_W   = 3;
    localparam int POS_W    = 3;
    localparam int TOKEN_W  = 12;
    localparam int SCORE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    localparam int SLOT_LSB  = 0;
    localparam int STEP_LSB  = SLOT_LSB + SLOT_W;
    localparam int POS_LSB   = STEP_LSB + STEP_W;
    localparam int TOKEN_LSB = POS_LSB + POS_W;
    localparam int SCORE_LSB = TOKEN_LSB + TOKEN_W;
    localparam int S_TDATA_W = ((SCORE_LSB + SCORE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + VALUE_W + 7) / 8) * 8;

    // Configuration registers.
    localparam int CFG_K_W    = 4;
    localparam int CFG_V_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_K_W-1:0] TOP_K_RESET = CFG_K_W'(8);
    localparam logic [CFG_V_W-1:0] VOCAB_RESET = CFG_V_W'(4096);

    // Compare widths wide enough for both the register and the store bound.
    localparam int KC_W   = ($clog2(MAX_TOP_K + 1) > CFG_K_W) ? $clog2(MAX_TOP_K + 1) : CFG_K_W;
    localparam int VCMP_W = ($clog2(VOCAB + 1) > CFG_V_W) ? $clog2(VOCAB + 1) : CFG_V_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [SCORE_W-1:0] NEG_INF_BITS = 32'hFF80_0000;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP_K = 1'b0,
        REG_VOCAB = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_STAGE = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2
    } cmd_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_APPLIED = 2'd0,
        STATUS_SKIPPED = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        cmd_op_t              op;
        status_t              status;
        logic [ROW_W-1:0]     row;
        logic [KIDX_W-1:0]    pos;
        logic [TOKEN_W-1:0]   token;
        logic [SCORE_W-1:0]   score;
    } cmd_t;

    function automatic logic [LADDR_W-1:0] logit_addr(input logic [ROW_W-1:0] row,
                                                      input logic [TOKEN_W-1:0] tok);
        logic [63:0] a;
        a = 64'(row) * 64'(VOCAB) + 64'(tok);
        return a[LADDR_W-1:0];
    endfunction

    function automatic logic [CADDR_W-1:0] cid_addr(input logic [ROW_W-1:0] row,
                                                    input logic [KIDX_W-1:0] idx);
        logic [63:0] a;
        a = 64'(row) * 64'(MAX_TOP_K) + 64'(idx);
        return a[CADDR_W-1:0];
    endfunction

endpackage

/* rtl/topk_logit_cache_scatter.sv */
// An applied read passes the command queue, the logit memory read and the result register; a
// failed read or a rejected or skipped row end passes the queue and the result register; an
// applied row end passes the queue, then holds the back end for a wipe pass and a write pass
// over the k in use (one wipe, one score each, on the single logit write port), then reports.
// Reset: synchronous, active low. A clearing pass over all 2,097,152 logit entries follows,
// one logit entry per cycle, the id store alongside; no input transfer is taken until it ends.
//
// Structure: the front end takes input transfers and classifies each one (stage a candidate,
// end a row, or read a logit), resolving the row index, the vocabulary check and the row status
// on the spot. Classified commands go through a four-entry queue to the back end, which owns
// the staging buffer, both memories and the result register. The back end commits a row in two
// passes: it first reads the old cached ids and writes minus infinity at each of them, then
// writes each staged score in position order (a later duplicate wins) while recording the new
// ids. Configuration writes may be taken at any time, but are meant only for an idle block.
module topk_logit_cache_scatter import tlcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port: index 0 top_k_used, index 1 vocab_used.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: slot[6:0], step[9:7], position[12:10], token[24:13], score[56:25].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Field: func (0 load candidate, 1 read one logit).
    input  logic                  s_tuser,
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: status[1:0], value[33:2].
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Field: kind (0 row completion report, 1 read data).
    output logic                  m_tuser
);
    logic push, pop, fifo_full, fifo_empty, clearing;
    cmd_t push_cmd, head;

    tlcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .clearing  (clearing),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tlcs_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .empty    (fifo_empty),
        .head     (head)
    );

    tlcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );
endmodule

/* rtl/tlcs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tlcs_ram #(
    parameter int     WIDTH = 32,
    parameter longint DEPTH = 1024,
    localparam int    AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/tlcs_front.sv */
// Front end: configuration registers, input acceptance and classification of items.
// Depends on tlcs_pkg; feeds classified commands into tlcs_fifo.
module tlcs_front import tlcs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   fifo_full,
    input  logic                   clearing,
    output logic                   push,
    output cmd_t                   push_cmd
);
    logic [CFG_K_W-1:0] top_k_used_reg, top_k_used_next;
    logic [CFG_V_W-1:0] vocab_used_reg, vocab_used_next;
    logic               row_bad_reg, row_bad_next;

    logic [SLOT_W-1:0]  slot;
    logic [STEP_W-1:0]  step;
    logic [POS_W-1:0]   pos;
    logic [TOKEN_W-1:0] token;
    logic [SCORE_W-1:0] score;
    logic [KC_W-1:0]    eff_k;
    logic [VCMP_W-1:0]  eff_vocab;
    logic               accept, is_read, row_ok, tok_bad, pos_in_use, row_end;

    assign slot  = s_tdata[SLOT_LSB +: SLOT_W];
    assign step  = s_tdata[STEP_LSB +: STEP_W];
    assign pos   = s_tdata[POS_LSB +: POS_W];
    assign token = s_tdata[TOKEN_LSB +: TOKEN_W];
    assign score = s_tdata[SCORE_LSB +: SCORE_W];

    assign s_tready = !clearing && !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign is_read  = s_tuser;

    always_comb begin
        if (top_k_used_reg == '0) begin
            eff_k = KC_W'(1);
        end else if (KC_W'(top_k_used_reg) > KC_W'(MAX_TOP_K)) begin
            eff_k = KC_W'(MAX_TOP_K);
        end else begin
            eff_k = KC_W'(top_k_used_reg);
        end
        if (VCMP_W'(vocab_used_reg) < VCMP_W'(VOCAB)) begin
            eff_vocab = VCMP_W'(vocab_used_reg);
        end else begin
            eff_vocab = VCMP_W'(VOCAB);
        end
    end

    // A negative slot (sign bit set) or a slot or step beyond the store skips the row.
    assign row_ok = !slot[SLOT_W-1] && (32'(slot[SLOT_W-2:0]) < SLOTS)
                    && (32'(step) < MAX_STEPS);
    assign tok_bad    = VCMP_W'(token) >= eff_vocab;
    assign pos_in_use = KC_W'(pos) < eff_k;
    assign row_end    = KC_W'(pos) == (eff_k - KC_W'(1));

    assign push = accept && (is_read || pos_in_use);

    always_comb begin
        push_cmd.row   = ROW_W'(32'(slot[SLOT_W-2:0]) * MAX_STEPS + 32'(step));
        push_cmd.pos   = KIDX_W'(pos);
        push_cmd.token = token;
        push_cmd.score = score;
        if (is_read) begin
            push_cmd.op = CMD_READ;
        end else if (row_end) begin
            push_cmd.op = CMD_END;
        end else begin
            push_cmd.op = CMD_STAGE;
        end
        if (!row_ok) begin
            push_cmd.status = STATUS_SKIPPED;
        end else if (tok_bad || (!is_read && row_bad_reg)) begin
            push_cmd.status = STATUS_RANGE;
        end else begin
            push_cmd.status = STATUS_APPLIED;
        end
    end

    always_comb begin
        top_k_used_next = top_k_used_reg;
        vocab_used_next = vocab_used_reg;
        row_bad_next    = row_bad_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_TOP_K: top_k_used_next = cfg_wdata[CFG_K_W-1:0];
                REG_VOCAB: vocab_used_next = cfg_wdata[CFG_V_W-1:0];
                default:   ;
            endcase
        end
        if (accept && !is_read && pos_in_use) begin
            row_bad_next = row_end ? 1'b0 : (row_bad_reg || tok_bad);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_k_used_reg <= TOP_K_RESET;
            vocab_used_reg <= VOCAB_RESET;
            row_bad_reg    <= 1'b0;
        end else begin
            top_k_used_reg <= top_k_used_next;
            vocab_used_reg <= vocab_used_next;
            row_bad_reg    <= row_bad_next;
        end
    end
endmodule

/* rtl/tlcs_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on tlcs_pkg for the command type and depth.
module tlcs_fifo import tlcs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);
    cmd_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W:0] wptr_reg, wptr_next;
    logic [FIFO_PTR_W:0] rptr_reg, rptr_next;

    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[FIFO_PTR_W] != rptr_reg[FIFO_PTR_W])
                   && (wptr_reg[FIFO_PTR_W-1:0] == rptr_reg[FIFO_PTR_W-1:0]);
    assign head  = entry_reg[rptr_reg[FIFO_PTR_W-1:0]];

    assign wptr_next = wptr_reg + (FIFO_PTR_W + 1)'(push);
    assign rptr_next = rptr_reg + (FIFO_PTR_W + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg[FIFO_PTR_W-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end
endmodule

/* rtl/tlcs_back.sv */
// Back end: staging buffer, row commit sequencer, logit reads, clearing pass and result register.
// Depends on tlcs_pkg and two instances of tlcs_ram.
module tlcs_back import tlcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fifo_empty,
    input  cmd_t                  head,
    output logic                  pop,
    output logic                  clearing,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_WIPE,
        ST_WRITE
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [KC_W-1:0]    idx_reg, idx_next;
    logic [KC_W-1:0]    kcnt_reg, kcnt_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_kind_reg, m_kind_next;
    status_t            m_status_reg, m_status_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;

    logic [TOKEN_W-1:0] stage_tok_reg [MAX_TOP_K];
    logic [SCORE_W-1:0] stage_score_reg [MAX_TOP_K];
    logic               stage_we;

    logic               l_we, l_re;
    logic [LADDR_W-1:0] l_waddr, l_raddr;
    logic [SCORE_W-1:0] l_wdata, l_rdata;
    logic               c_we, c_re;
    logic [CADDR_W-1:0] c_waddr, c_raddr;
    logic [TOKEN_W-1:0] c_wdata, c_rdata;

    logic               out_free, last_idx;
    logic [KC_W-1:0]    idx_inc;
    logic [TOKEN_W-1:0] cur_tok;

    assign out_free = !m_tvalid_reg || m_tready;
    assign last_idx = (idx_reg == (kcnt_reg - KC_W'(1)));
    assign idx_inc  = idx_reg + KC_W'(1);
    assign cur_tok  = stage_tok_reg[idx_reg[KIDX_W-1:0]];
    assign clearing = (state_reg == ST_CLEAR);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        idx_next      = idx_reg;
        kcnt_next     = kcnt_reg;
        row_next      = row_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        pop      = 1'b0;
        stage_we = 1'b0;
        l_we     = 1'b0;
        l_waddr  = '0;
        l_wdata  = NEG_INF_BITS;
        l_re     = 1'b0;
        l_raddr  = logit_addr(head.row, head.token);
        c_we     = 1'b0;
        c_waddr  = '0;
        c_wdata  = '0;
        c_re     = 1'b0;
        c_raddr  = cid_addr(head.row, '0);

        case (state_reg)
            ST_CLEAR: begin
                if (64'(clr_cnt_reg) < 64'(LOGIT_DEPTH)) begin
                    l_we    = 1'b1;
                    l_waddr = LADDR_W'(clr_cnt_reg);
                end
                if (64'(clr_cnt_reg) < 64'(CID_DEPTH)) begin
                    c_we    = 1'b1;
                    c_waddr = CADDR_W'(clr_cnt_reg);
                end
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end
            ST_IDLE: begin
                if (!fifo_empty && (head.op == CMD_STAGE || out_free)) begin
                    pop      = 1'b1;
                    stage_we = (head.op != CMD_READ);
                    case (head.op)
                        CMD_STAGE: ;
                        CMD_END: begin
                            if (head.status == STATUS_APPLIED) begin
                                c_re       = 1'b1;
                                row_next   = head.row;
                                kcnt_next  = KC_W'(head.pos) + KC_W'(1);
                                idx_next   = '0;
                                state_next = ST_WIPE;
                            end else begin
                                m_tvalid_next = 1'b1;
                                m_kind_next   = KIND_REPORT;
                                m_status_next = head.status;
                                m_value_next  = '0;
                            end
                        end
                        CMD_READ: begin
                            m_kind_next = KIND_READ;
                            if (head.status == STATUS_APPLIED) begin
                                l_re       = 1'b1;
                                state_next = ST_RD_WAIT;
                            end else begin
                                m_tvalid_next = 1'b1;
                                m_status_next = head.status;
                                m_value_next  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                m_tvalid_next = 1'b1;
                m_status_next = STATUS_APPLIED;
                m_value_next  = l_rdata;
                state_next    = ST_IDLE;
            end
            ST_WIPE: begin
                // The previously cached id of this position arrives from the id store.
                if (32'(c_rdata) < VOCAB) begin
                    l_we    = 1'b1;
                    l_waddr = logit_addr(row_reg, c_rdata);
                    l_wdata = NEG_INF_BITS;
                end
                if (last_idx) begin
                    idx_next   = '0;
                    state_next = ST_WRITE;
                end else begin
                    c_re     = 1'b1;
                    c_raddr  = cid_addr(row_reg, idx_inc[KIDX_W-1:0]);
                    idx_next = idx_inc;
                end
            end
            ST_WRITE: begin
                if (32'(cur_tok) < VOCAB) begin
                    l_we    = 1'b1;
                    l_waddr = logit_addr(row_reg, cur_tok);
                    l_wdata = stage_score_reg[idx_reg[KIDX_W-1:0]];
                end
                c_we    = 1'b1;
                c_waddr = cid_addr(row_reg, idx_reg[KIDX_W-1:0]);
                c_wdata = cur_tok;
                if (last_idx) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_REPORT;
                    m_status_next = STATUS_APPLIED;
                    m_value_next  = '0;
                    state_next    = ST_IDLE;
                end else begin
                    idx_next = idx_inc;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_we) begin
            stage_tok_reg[head.pos]   <= head.token;
            stage_score_reg[head.pos] <= head.score;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            idx_reg      <= '0;
            kcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            idx_reg      <= idx_next;
            kcnt_reg     <= kcnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        row_reg      <= row_next;
        m_kind_reg   <= m_kind_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
    end

    tlcs_ram #(.WIDTH(SCORE_W), .DEPTH(LOGIT_DEPTH)) u_logit_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    tlcs_ram #(.WIDTH(TOKEN_W), .DEPTH(CID_DEPTH)) u_cid_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - STATUS_W){1'b0}}, m_value_reg, m_status_reg};
endmodule

/* rtl/tlcs_checker.sv */
// Port-level checks for topk_logit_cache_scatter, attached to it with a bind statement.
// Depends on tlcs_pkg for port widths.
module tlcs_checker import tlcs_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tuser
);
    // Reset empties the result register and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result pending or input ready right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Row reports and failed reads carry a zero value.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REPORT || m_tdata[1:0] != STATUS_APPLIED)
        |-> m_tdata[VALUE_W+STATUS_W-1:STATUS_W] == '0)
        else $error("nonzero value in report or failed read");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");
endmodule

bind topk_logit_cache_scatter tlcs_checker u_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench for the top-k logit cache scatter block: random and directed stream
// traffic with an in-bench prediction of the logit store, cached ids and row reports.
// Depends on tlcs_pkg and topk_logit_cache_scatter from the rtl folder.
module tb;
    import tlcs_pkg::*;

    // Codes carried on s_tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Raw slot pattern of a negative slot (minus one in seven bits).
    localparam logic [SLOT_W-1:0] SLOT_SKIP = 7'h7F;

    // Cycles allowed after the last expected result before the block is considered idle.
    // This covers the wipe and write passes of the widest row with margin.
    localparam int SETTLE_CYCLES = 40;

    // Random items per configuration phase; seven phases give about 1330 items.
    localparam int PHASE_ITEMS = 190;

    // One input transfer as the bench sees it, before it is packed onto the bus.
    typedef struct {
        logic                func;
        logic [SLOT_W-1:0]   slot;
        logic [STEP_W-1:0]   step;
        logic [POS_W-1:0]    pos;
        logic [TOKEN_W-1:0]  token;
        logic [SCORE_W-1:0]  score;
    } cache_req_t;

    // One result transfer: kind on m_tuser, status and value on m_tdata.
    typedef struct {
        logic                kind;
        status_t             status;
        logic [VALUE_W-1:0]  value;
    } cache_reply_t;

    // A recently loaded (slot, step, token), kept so that reads can hit live entries.
    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [STEP_W-1:0]   step;
        logic [TOKEN_W-1:0]  token;
    } hot_entry_t;

    // Every input starts at a known value; the driver and the main sequence take over later.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TOP_K;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // Fields from bit 0: slot[6:0], step[9:7], position[12:10], token[24:13], score[56:25].
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // Field: func (0 load candidate, 1 read one logit).
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // Fields from bit 0: status[1:0], value[33:2].
    logic [M_TDATA_W-1:0]  m_tdata;
    // Field: kind (0 row completion report, 1 read data).
    logic                  m_tuser;

    // Items waiting to be driven, and results the block still owes, oldest first.
    cache_req_t   request_q[$];
    cache_reply_t reply_due_q[$];
    hot_entry_t   hot_q[$];

    // The bench's own copy of the block state. Logit entries that were never written are
    // absent from the associative array and read as minus infinity.
    logic [SCORE_W-1:0] logit_mem [int unsigned];
    logic [TOKEN_W-1:0] cid_mem   [ROWS*MAX_TOP_K] = '{default: '0};
    logic [TOKEN_W-1:0] stage_tok   [MAX_TOP_K]    = '{default: '0};
    logic [SCORE_W-1:0] stage_score [MAX_TOP_K]    = '{default: '0};
    logic               row_bad   = 1'b0;
    logic [CFG_K_W-1:0] mdl_k     = TOP_K_RESET;
    logic [CFG_V_W-1:0] mdl_vocab = VOCAB_RESET;

    // Settings the stimulus generator shapes its rows for (always within 1..8 and 1..4096).
    int ge_k = MAX_TOP_K;
    int ge_v = VOCAB;

    int err_cnt = 0;

    // Driver and monitor pacing. A calm flag suppresses idling for a stretch of transfers.
    cache_req_t cur_req;
    int         gap_left   = 0;
    int         stall_left = 0;
    bit         drv_calm   = 1'b0;
    bit         mon_calm   = 1'b0;

    topk_logit_cache_scatter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Works out what one accepted item does to the cache state and which result it causes.
    // Returns 1 when the item produces a result transfer.
    function automatic bit apply_cache_item(input cache_req_t rq, output cache_reply_t rp);
        int unsigned k_eff;
        int unsigned v_eff;
        int unsigned row;
        int unsigned i;
        bit          row_ok;
        k_eff  = (mdl_k == 0) ? 1 : ((mdl_k > MAX_TOP_K) ? MAX_TOP_K : mdl_k);
        v_eff  = (mdl_vocab < VOCAB) ? mdl_vocab : VOCAB;
        row_ok = !rq.slot[SLOT_W-1] && (rq.slot < SLOTS) && (rq.step < MAX_STEPS);
        row    = int'(rq.slot[SLOT_W-2:0]) * MAX_STEPS + int'(rq.step);
        rp.value = '0;

        if (rq.func == FUNC_READ) begin
            rp.kind = KIND_READ;
            if (!row_ok) begin
                rp.status = STATUS_SKIPPED;
            end else if (rq.token >= v_eff) begin
                rp.status = STATUS_RANGE;
            end else begin
                rp.status = STATUS_APPLIED;
                if (logit_mem.exists(row * VOCAB + rq.token))
                    rp.value = logit_mem[row * VOCAB + rq.token];
                else
                    rp.value = NEG_INF_BITS;
            end
            return 1'b1;
        end

        // A load at a position beyond the row width is dropped without any effect.
        if (rq.pos >= k_eff)
            return 1'b0;
        stage_tok[rq.pos]   = rq.token;
        stage_score[rq.pos] = rq.score;
        if (rq.token >= v_eff)
            row_bad = 1'b1;
        if (rq.pos != k_eff - 1)
            return 1'b0;

        rp.kind = KIND_REPORT;
        if (!row_ok) begin
            rp.status = STATUS_SKIPPED;
        end else if (row_bad) begin
            rp.status = STATUS_RANGE;
        end else begin
            // Wipe the previous ids first, then scatter the new scores in position order so
            // that a later duplicate token overwrites an earlier one.
            for (i = 0; i < k_eff; i++)
                logit_mem[row * VOCAB + cid_mem[row * MAX_TOP_K + i]] = NEG_INF_BITS;
            for (i = 0; i < k_eff; i++) begin
                logit_mem[row * VOCAB + stage_tok[i]] = stage_score[i];
                cid_mem[row * MAX_TOP_K + i] = stage_tok[i];
            end
            rp.status = STATUS_APPLIED;
        end
        row_bad = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // Driver: presents the next queued item once the previous transfer is done and the drawn
    // gap has run out. Each transfer is handed to the predictor at the edge that accepts it.
    always @(posedge aclk) begin
        cache_reply_t rp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (apply_cache_item(cur_req, rp))
                    reply_due_q.push_back(rp);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    s_tdata <= S_TDATA_W'({cur_req.score, cur_req.token, cur_req.pos,
                                           cur_req.step, cur_req.slot});
                    s_tuser  <= cur_req.func;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        drv_calm = !drv_calm;
                    gap_left = drv_calm ? 0 : $urandom_range(0, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transfer against the oldest outstanding expectation and
    // draws a stall of m_tready after each one.
    always @(posedge aclk) begin
        cache_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_due_q.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_tdata[STATUS_W +: VALUE_W]);
                end else begin
                    want = reply_due_q.pop_front();
                    if (m_tuser !== want.kind)
                        note_mismatch("kind", VALUE_W'(want.kind), VALUE_W'(m_tuser));
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                        note_mismatch("status", VALUE_W'(want.status),
                                      VALUE_W'(m_tdata[STATUS_W-1:0]));
                    if (m_tdata[STATUS_W +: VALUE_W] !== want.value)
                        note_mismatch("value", want.value, m_tdata[STATUS_W +: VALUE_W]);
                end
                if ($urandom_range(0, 49) == 0)
                    mon_calm = !mon_calm;
                stall_left = mon_calm ? 0 : $urandom_range(0, 9);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_req(input logic func, input logic [SLOT_W-1:0] slot,
                            input logic [STEP_W-1:0] step, input logic [POS_W-1:0] pos,
                            input logic [TOKEN_W-1:0] token, input logic [SCORE_W-1:0] score);
        cache_req_t rq;
        hot_entry_t he;
        rq = '{func, slot, step, pos, token, score};
        request_q.push_back(rq);
        if (func == FUNC_LOAD) begin
            he = '{slot, step, token};
            hot_q.push_back(he);
            if (hot_q.size() > 32)
                void'(hot_q.pop_front());
        end
    endtask

    // Slots lean toward a few hot rows so that reads find written entries; some are negative.
    function automatic logic [SLOT_W-1:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SLOT_SKIP;
        if (r < 40) begin
            case ($urandom_range(0, 3))
                0: return 7'd0;
                1: return 7'd1;
                2: return 7'd62;
                default: return 7'd63;
            endcase
        end
        return SLOT_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // An in-range token: extremes, repeats of recent ones (duplicates within a row) or random.
    function automatic logic [TOKEN_W-1:0] pick_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15 && hot_q.size() != 0) begin
            r = hot_q[$urandom_range(0, hot_q.size() - 1)].token;
            if (r < ge_v)
                return TOKEN_W'(r);
        end else if (r < 20) begin
            return '0;
        end else if (r < 25) begin
            return TOKEN_W'(ge_v - 1);
        end
        return TOKEN_W'($urandom_range(0, ge_v - 1));
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 5))
                0: return 32'h0000_0000;
                1: return NEG_INF_BITS;
                2: return 32'h7F80_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h8000_0000;
                default: return 32'h7FC0_0000;
            endcase
        end
        return $urandom;
    endfunction

    // A token the current vocabulary rejects; only called while one exists.
    function automatic logic [TOKEN_W-1:0] bad_token();
        return TOKEN_W'($urandom_range(ge_v, VOCAB - 1));
    endfunction

    task automatic push_read();
        int         r;
        hot_entry_t he;
        r = $urandom_range(0, 99);
        if (r < 50 && hot_q.size() != 0) begin
            he = hot_q[$urandom_range(0, hot_q.size() - 1)];
        end else begin
            he.slot  = pick_slot();
            he.step  = STEP_W'($urandom_range(0, MAX_STEPS - 1));
            he.token = TOKEN_W'($urandom_range(0, VOCAB - 1));
        end
        push_req(FUNC_READ, he.slot, he.step, POS_W'($urandom_range(0, 7)), he.token, $urandom);
    endtask

    // Fills the stimulus for one phase. Most of it is complete rows with random content and
    // the odd read between candidates; the rest is reads, dropped positions, rows that are
    // abandoned halfway and lone row ends that commit whatever is staged.
    task automatic gen_phase(input int n);
        int                  made;
        int                  sel;
        int                  j;
        int                  bad_pos;
        logic [SLOT_W-1:0]   sl;
        logic [STEP_W-1:0]   st;
        logic [TOKEN_W-1:0]  tk;
        made = 0;
        while (made < n) begin
            sel = $urandom_range(0, 99);
            sl  = pick_slot();
            st  = STEP_W'($urandom_range(0, MAX_STEPS - 1));
            if (sel < 60) begin
                bad_pos = -1;
                if (ge_v < VOCAB && $urandom_range(0, 4) == 0)
                    bad_pos = $urandom_range(0, ge_k - 1);
                for (j = 0; j < ge_k; j++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_read();
                        made++;
                    end
                    tk = (j == bad_pos) ? bad_token() : pick_token();
                    push_req(FUNC_LOAD, sl, st, POS_W'(j), tk, pick_score());
                    made++;
                end
            end else if (sel < 78 || (sel < 88 && ge_k == MAX_TOP_K)) begin
                push_read();
                made++;
            end else if (sel < 88) begin
                // Position past the row width: dropped, so it does not count as an item.
                push_req(FUNC_LOAD, sl, st, POS_W'($urandom_range(ge_k, MAX_TOP_K - 1)),
                         TOKEN_W'($urandom), $urandom);
            end else if (ge_k > 1 && $urandom_range(0, 1) == 0) begin
                // Abandoned row: a few candidates, possibly a bad one that poisons the next
                // row end, and no closing position.
                for (j = $urandom_range(1, ge_k - 1); j > 0; j--) begin
                    tk = (ge_v < VOCAB && $urandom_range(0, 9) == 0) ? bad_token()
                                                                    : pick_token();
                    push_req(FUNC_LOAD, sl, st, POS_W'($urandom_range(0, ge_k - 2)), tk,
                             pick_score());
                    made++;
                end
            end else begin
                push_req(FUNC_LOAD, sl, st, POS_W'(ge_k - 1), pick_token(), pick_score());
                made++;
            end
        end
    endtask

    // Holds the sender back until every queued item went out and every result came back,
    // then lets the block finish any work that produces no result.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (request_q.size() != 0 || s_tvalid || reply_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input int k, input int v);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TOP_K;
        cfg_wdata <= CFG_DATA_W'(k);
        @(posedge aclk);
        cfg_index <= REG_VOCAB;
        cfg_wdata <= CFG_DATA_W'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mdl_k     = CFG_K_W'(k);
        mdl_vocab = CFG_V_W'(v);
        ge_k      = k;
        ge_v      = v;
    endtask

    // Main sequence: reset, a directed opening under the reset settings, then phases of
    // random traffic under settings that include both ends of the store bounds for each register.
    initial begin
        logic [TOKEN_W-1:0] dir_tok   [MAX_TOP_K];
        logic [SCORE_W-1:0] dir_score [MAX_TOP_K];
        int                 cfg_k_list [6];
        int                 cfg_v_list [6];
        int                 i;
        dir_tok   = '{12'd0, 12'd4095, 12'd5, 12'd2048, 12'd5, 12'd1, 12'd2047, 12'd3};
        dir_score = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h1234_5678,
                      32'h3F80_0000, NEG_INF_BITS, 32'h8000_0000, 32'h7FC0_0000};
        cfg_k_list = '{1, 8, 3, 5, 2, 0};
        cfg_v_list = '{1, 4096, 100, 4095, 2048, 0};
        cfg_k_list[5] = $urandom_range(1, MAX_TOP_K);
        cfg_v_list[5] = $urandom_range(1, VOCAB);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reads of a freshly cleared store, including a skipped slot and the far corner.
        push_req(FUNC_READ, 7'd0, 3'd0, 3'd0, 12'd0, 32'h0000_0000);
        push_req(FUNC_READ, SLOT_SKIP, 3'd7, 3'd7, 12'hFFF, 32'hFFFF_FFFF);
        push_req(FUNC_READ, 7'd63, 3'd7, 3'd0, 12'hFFF, 32'h0000_0000);
        // A full row with extreme tokens and scores and one duplicate token; this also
        // fills every staging entry, so later lone row ends never see unwritten entries.
        for (i = 0; i < MAX_TOP_K; i++)
            push_req(FUNC_LOAD, 7'd0, 3'd0, POS_W'(i), dir_tok[i], dir_score[i]);
        push_req(FUNC_READ, 7'd0, 3'd0, 3'd0, 12'd5, 32'h0);
        push_req(FUNC_READ, 7'd0, 3'd0, 3'd0, 12'd4095, 32'h0);
        push_req(FUNC_READ, 7'd0, 3'd0, 3'd0, 12'd100, 32'h0);
        // Row end on a negative slot, then a lone row end that commits the staged row to the
        // last slot and step, and two reads of it.
        push_req(FUNC_LOAD, SLOT_SKIP, 3'd0, 3'd7, 12'd7, 32'h4000_0000);
        push_req(FUNC_LOAD, 7'd63, 3'd7, 3'd7, 12'd3, 32'h7FC0_0000);
        push_req(FUNC_READ, 7'd63, 3'd7, 3'd0, 12'd4095, 32'h0);
        push_req(FUNC_READ, 7'd63, 3'd7, 3'd0, 12'd3, 32'h0);
        gen_phase(PHASE_ITEMS);

        for (i = 0; i < 6; i++) begin
            set_config(cfg_k_list[i], cfg_v_list[i]);
            gen_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // The clearing pass after reset runs over every logit entry, and the traffic itself is
    // far shorter even at the slowest pacing; the time limit below is several times what
    // a full run needs.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
